### sv/tbsc_pkg.sv
// Shared types, codes and the storage layout table of the tensor byte size checker.
package tbsc_pkg;

   localparam int unsigned MAX_DIMS = 4;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned BYTES_W  = 9;
   localparam int unsigned SHIFT_W  = 4;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FORMAT      = 2'd1,
      ST_RANGE       = 2'd2,
      ST_UNSUPPORTED = 2'd3
   } status_type;

   typedef enum logic {
      CSR_FILE_LENGTH = 1'b0,
      CSR_DATA_START  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               known;
      logic [SHIFT_W-1:0] blk_shift;
      logic [BYTES_W-1:0] blk_bytes;
   } layout_type;

   typedef struct packed {
      logic format;
      logic unknown;
      logic ragged;
   } flags_type;

   typedef struct packed {
      flags_type          flags;
      logic [WORD_W-1:0]  d1;
      logic [WORD_W-1:0]  d2;
      logic [WORD_W-1:0]  d3;
      logic [WORD_W-1:0]  per_row;
      logic [BYTES_W-1:0] blk_bytes;
      logic [WORD_W-1:0]  offset;
   } item_type;

   function automatic layout_type mk(input logic [SHIFT_W-1:0] sh, input logic [BYTES_W-1:0] by);
      layout_type r;
      r.known     = 1'b1;
      r.blk_shift = sh;
      r.blk_bytes = by;
      return r;
   endfunction

   function automatic layout_type layout_of(input logic [31:0] code);
      layout_type r;
      r = '0;
      unique case (code)
         32'd0: r = mk(4'd0, 9'd4);
         32'd1: r = mk(4'd0, 9'd2);
         32'd2: r = mk(4'd5, 9'd18);
         32'd3: r = mk(4'd5, 9'd20);
         32'd4: r = mk(4'd0, 9'd8);
         32'd6: r = mk(4'd5, 9'd22);
         32'd7: r = mk(4'd5, 9'd24);
         32'd8: r = mk(4'd5, 9'd34);
         32'd9: r = mk(4'd5, 9'd36);
         32'd10: r = mk(4'd8, 9'd84);
         32'd11: r = mk(4'd8, 9'd110);
         32'd12: r = mk(4'd8, 9'd144);
         32'd13: r = mk(4'd8, 9'd176);
         32'd14: r = mk(4'd8, 9'd210);
         32'd15: r = mk(4'd8, 9'd292);
         32'd16: r = mk(4'd8, 9'd66);
         32'd17: r = mk(4'd8, 9'd74);
         32'd18: r = mk(4'd8, 9'd98);
         32'd19: r = mk(4'd8, 9'd50);
         32'd20: r = mk(4'd5, 9'd18);
         32'd21: r = mk(4'd8, 9'd110);
         32'd22: r = mk(4'd8, 9'd82);
         32'd23: r = mk(4'd8, 9'd136);
         32'd24: r = mk(4'd0, 9'd1);
         32'd25: r = mk(4'd0, 9'd2);
         32'd26: r = mk(4'd0, 9'd4);
         32'd27: r = mk(4'd0, 9'd8);
         32'd28: r = mk(4'd0, 9'd8);
         32'd29: r = mk(4'd8, 9'd56);
         32'd30: r = mk(4'd0, 9'd2);
         32'd39: r = mk(4'd5, 9'd17);
         32'd40: r = mk(4'd6, 9'd36);
         32'd41: r = mk(4'd5, 9'd18);
         32'd42: r = mk(4'd6, 9'd18);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### sv/tensor_byte_size_check.sv
// Top level of the tensor byte size checker: registers, front end, queue and back end.
// A word passes the queue entry, the four multipliers and the response register in order.
// Throughput: one word per cycle, set by the four three-stage multipliers in the back end.
// busy rises only if the queue fills, which never happens since the back end never stalls.
// Reset clears both configuration registers to zero and drops all words in flight.
module tensor_byte_size_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic  [3:0] req_dim_count,
   input  logic [63:0] req_dim_zero,
   input  logic [63:0] req_dim_one,
   input  logic [63:0] req_dim_two,
   input  logic [63:0] req_dim_three,
   input  logic [31:0] req_storage_type,
   input  logic [63:0] req_data_offset,
   output logic        rsp_valid,
   output logic  [1:0] rsp_status,
   output logic [63:0] rsp_byte_count,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import tbsc_pkg::*;

   logic [63:0] file_length_ff;
   logic [63:0] data_start_ff;
   item_type    front_item;
   item_type    queue_item;
   logic        queue_full;
   logic        queue_valid;
   logic        accept;

   assign accept = start && !busy;
   assign busy   = queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= 64'd0;
         data_start_ff  <= 64'd0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_FILE_LENGTH) begin
            file_length_ff <= csr_wdata;
         end else begin
            data_start_ff <= csr_wdata;
         end
      end
   end

   tbsc_front u_front (
      .req_dim_count   (req_dim_count),
      .req_dim_zero    (req_dim_zero),
      .req_dim_one     (req_dim_one),
      .req_dim_two     (req_dim_two),
      .req_dim_three   (req_dim_three),
      .req_storage_type(req_storage_type),
      .req_data_offset (req_data_offset),
      .item            (front_item)
   );

   tbsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_item(front_item),
      .full     (queue_full),
      .pop_valid(queue_valid),
      .pop_item (queue_item)
   );

   tbsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .file_length   (file_length_ff),
      .data_start    (data_start_ff),
      .item_valid    (queue_valid),
      .item          (queue_item),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_byte_count(rsp_byte_count)
   );

endmodule

### sv/tbsc_mul64.sv
// Three stage 64 by 64 multiplier with overflow detection and a side channel.
module tbsc_mul64 #(
   parameter int unsigned SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [63:0]       in_a,
   input  logic [63:0]       in_b,
   input  logic              in_ovf,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [63:0]       out_p,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   logic              v1_ff, v2_ff, v3_ff;
   logic [63:0]       low1_ff, low2_ff;
   logic [31:0]       xa1_ff, xb1_ff;
   logic [63:0]       cross2_ff;
   logic              both1_ff, both2_ff;
   logic              ovf1_ff, ovf2_ff, ovf3_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff;
   logic [63:0]       p3_ff;
   logic              a_hi_nz;
   logic              b_hi_nz;
   logic [32:0]       hi_sum;

   assign a_hi_nz = in_a[63:32] != 32'd0;
   assign b_hi_nz = in_b[63:32] != 32'd0;
   assign hi_sum  = {1'b0, cross2_ff[31:0]} + {1'b0, low2_ff[63:32]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      low1_ff  <= in_a[31:0] * in_b[31:0];
      xa1_ff   <= a_hi_nz ? in_a[63:32] : in_b[63:32];
      xb1_ff   <= a_hi_nz ? in_b[31:0] : in_a[31:0];
      both1_ff <= a_hi_nz && b_hi_nz;
      ovf1_ff  <= in_ovf;
      side1_ff <= in_side;

      cross2_ff <= xa1_ff * xb1_ff;
      low2_ff   <= low1_ff;
      both2_ff  <= both1_ff;
      ovf2_ff   <= ovf1_ff;
      side2_ff  <= side1_ff;

      p3_ff    <= {hi_sum[31:0], low2_ff[31:0]};
      ovf3_ff  <= ovf2_ff || both2_ff || (cross2_ff[63:32] != 32'd0) || hi_sum[32];
      side3_ff <= side2_ff;
   end

   assign out_valid = v3_ff;
   assign out_p     = p3_ff;
   assign out_ovf   = ovf3_ff;
   assign out_side  = side3_ff;

endmodule

### sv/tbsc_front.sv
// Front end: format check, type lookup, block split and operand selection.
module tbsc_front (
   input  logic                  [3:0] req_dim_count,
   input  logic                 [63:0] req_dim_zero,
   input  logic                 [63:0] req_dim_one,
   input  logic                 [63:0] req_dim_two,
   input  logic                 [63:0] req_dim_three,
   input  logic                 [31:0] req_storage_type,
   input  logic                 [63:0] req_data_offset,
   output tbsc_pkg::item_type          item
);
   import tbsc_pkg::*;

   layout_type  lay;
   logic        zero_dim;
   logic [63:0] fast;
   logic [63:0] mask;

   always_comb begin
      lay      = layout_of(req_storage_type);
      zero_dim = ((req_dim_count > 4'd0) && (req_dim_zero == 64'd0))
              || ((req_dim_count > 4'd1) && (req_dim_one == 64'd0))
              || ((req_dim_count > 4'd2) && (req_dim_two == 64'd0))
              || ((req_dim_count > 4'd3) && (req_dim_three == 64'd0));
      fast     = (req_dim_count != 4'd0) ? req_dim_zero : 64'd1;
      mask     = (64'd1 << lay.blk_shift) - 64'd1;

      item.flags.format  = (req_dim_count > 4'(MAX_DIMS)) || zero_dim;
      item.flags.unknown = !lay.known;
      item.flags.ragged  = (fast & mask) != 64'd0;
      item.d1            = (req_dim_count > 4'd1) ? req_dim_one : 64'd1;
      item.d2            = (req_dim_count > 4'd2) ? req_dim_two : 64'd1;
      item.d3            = (req_dim_count > 4'd3) ? req_dim_three : 64'd1;
      item.per_row       = fast >> lay.blk_shift;
      item.blk_bytes     = lay.blk_bytes;
      item.offset        = req_data_offset;
   end

endmodule

### sv/tbsc_queue.sv
// Two entry queue between the front end and the back end.
module tbsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tbsc_pkg::item_type push_item,
   output logic               full,
   output logic               pop_valid,
   output tbsc_pkg::item_type pop_item
);
   import tbsc_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = count_ff == 2'd2;
   assign pop       = count_ff != 2'd0;
   assign pop_valid = pop;
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/tbsc_back.sv
// Back end: row and size product chain, file bounds check and status select.
module tbsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                [63:0] file_length,
   input  logic                [63:0] data_start,
   input  logic                       item_valid,
   input  tbsc_pkg::item_type         item,
   output logic                       rsp_valid,
   output logic                 [1:0] rsp_status,
   output logic                [63:0] rsp_byte_count
);
   import tbsc_pkg::*;

   typedef struct packed {
      logic [63:0]        d3;
      logic [63:0]        per_row;
      logic [BYTES_W-1:0] blk_bytes;
      logic [63:0]        offset;
      flags_type          flags;
   } s1_type;

   typedef struct packed {
      logic [63:0]        per_row;
      logic [BYTES_W-1:0] blk_bytes;
      logic [63:0]        offset;
      flags_type          flags;
   } s2_type;

   typedef struct packed {
      logic [BYTES_W-1:0] blk_bytes;
      logic               row_ovf;
      logic               start_past;
      logic               off_bad;
      logic [63:0]        avail;
      flags_type          flags;
   } s3_type;

   typedef struct packed {
      logic        row_ovf;
      logic        start_past;
      logic        off_bad;
      logic [63:0] avail;
      flags_type   flags;
   } s4_type;

   s1_type      s1_in, s1_out;
   s2_type      s2_in, s2_out;
   s3_type      s3_in, s3_out;
   s4_type      s4_in, s4_out;
   logic        v1, v2, v3, v4;
   logic [63:0] p1, p2, p3, p4;
   logic        o1, o2, o3, o4;
   logic [64:0] room_diff;
   logic [63:0] room_ff;
   logic        start_past_ff;
   logic [64:0] avail_diff;

   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic [63:0] byte_count_ff, byte_count_in;

   assign room_diff = {1'b0, file_length} - {1'b0, data_start};

   always_ff @(posedge clock) begin
      if (reset) begin
         room_ff       <= 64'd0;
         start_past_ff <= 1'b0;
      end else begin
         room_ff       <= room_diff[63:0];
         start_past_ff <= room_diff[64];
      end
   end

   always_comb begin
      s1_in.d3        = item.d3;
      s1_in.per_row   = item.per_row;
      s1_in.blk_bytes = item.blk_bytes;
      s1_in.offset    = item.offset;
      s1_in.flags     = item.flags;
   end

   tbsc_mul64 #(.SIDE_W($bits(s1_type))) u_mul_rows_a (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item_valid),
      .in_a     (item.d1),
      .in_b     (item.d2),
      .in_ovf   (1'b0),
      .in_side  (s1_in),
      .out_valid(v1),
      .out_p    (p1),
      .out_ovf  (o1),
      .out_side (s1_out)
   );

   always_comb begin
      s2_in.per_row   = s1_out.per_row;
      s2_in.blk_bytes = s1_out.blk_bytes;
      s2_in.offset    = s1_out.offset;
      s2_in.flags     = s1_out.flags;
   end

   tbsc_mul64 #(.SIDE_W($bits(s2_type))) u_mul_rows_b (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1),
      .in_a     (p1),
      .in_b     (s1_out.d3),
      .in_ovf   (o1),
      .in_side  (s2_in),
      .out_valid(v2),
      .out_p    (p2),
      .out_ovf  (o2),
      .out_side (s2_out)
   );

   always_comb begin
      avail_diff       = {1'b0, room_ff} - {1'b0, s2_out.offset};
      s3_in.blk_bytes  = s2_out.blk_bytes;
      s3_in.row_ovf    = o2;
      s3_in.start_past = start_past_ff;
      s3_in.off_bad    = avail_diff[64];
      s3_in.avail      = avail_diff[63:0];
      s3_in.flags      = s2_out.flags;
   end

   tbsc_mul64 #(.SIDE_W($bits(s3_type))) u_mul_size_a (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v2),
      .in_a     (p2),
      .in_b     (s2_out.per_row),
      .in_ovf   (1'b0),
      .in_side  (s3_in),
      .out_valid(v3),
      .out_p    (p3),
      .out_ovf  (o3),
      .out_side (s3_out)
   );

   always_comb begin
      s4_in.row_ovf    = s3_out.row_ovf;
      s4_in.start_past = s3_out.start_past;
      s4_in.off_bad    = s3_out.off_bad;
      s4_in.avail      = s3_out.avail;
      s4_in.flags      = s3_out.flags;
   end

   tbsc_mul64 #(.SIDE_W($bits(s4_type))) u_mul_size_b (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3),
      .in_a     (p3),
      .in_b     ({{(64-BYTES_W){1'b0}}, s3_out.blk_bytes}),
      .in_ovf   (o3),
      .in_side  (s4_in),
      .out_valid(v4),
      .out_p    (p4),
      .out_ovf  (o4),
      .out_side (s4_out)
   );

   always_comb begin
      byte_count_in = 64'd0;
      priority if (s4_out.flags.format) begin
         status_in = ST_FORMAT;
      end else if (s4_out.row_ovf) begin
         status_in = ST_RANGE;
      end else if (s4_out.flags.unknown || s4_out.flags.ragged || o4) begin
         status_in = ST_UNSUPPORTED;
      end else if (s4_out.start_past || s4_out.off_bad || (p4 > s4_out.avail)) begin
         status_in = ST_RANGE;
      end else begin
         status_in     = ST_OK;
         byte_count_in = p4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v4;
      end
      status_ff     <= status_in;
      byte_count_ff <= byte_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_byte_count = byte_count_ff;

endmodule

### dv/tensor_byte_size_check_tb.sv
// Self-checking testbench of the tensor byte size checker: directed table, random phases.
`timescale 1ns / 1ps

module tensor_byte_size_check_tb;
   import tbsc_pkg::*;

   localparam int unsigned NUM_DIRECTED    = 25;
   localparam int unsigned NUM_PHASES      = 10;
   localparam int unsigned WORDS_PER_PHASE = 95;
   localparam int unsigned STALL_LIMIT     = 2000;

   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [63:0] ZERO     = '0;
   localparam logic [63:0] BIT32    = 64'h1_0000_0000;
   localparam logic [63:0] BIT62    = 64'h4000_0000_0000_0000;

   localparam logic [31:0] KIND_W32      = 32'd0;
   localparam logic [31:0] KIND_W16      = 32'd1;
   localparam logic [31:0] KIND_B32_18   = 32'd2;
   localparam logic [31:0] KIND_GAP      = 32'd5;
   localparam logic [31:0] KIND_B256_84  = 32'd10;
   localparam logic [31:0] KIND_B256_292 = 32'd15;
   localparam logic [31:0] KIND_W8       = 32'd24;
   localparam logic [31:0] KIND_HOLE     = 32'd31;
   localparam logic [31:0] KIND_B64_36   = 32'd40;
   localparam logic [31:0] KIND_PAST_END = 32'd43;
   localparam logic [31:0] KIND_TOP      = '1;

   typedef struct packed {
      logic [3:0]  dims_n;
      logic [63:0] d0;
      logic [63:0] d1;
      logic [63:0] d2;
      logic [63:0] d3;
      logic [31:0] kind;
      logic [63:0] off;
   } tensor_word_type;

   typedef struct packed {
      status_type  st;
      logic [63:0] nbytes;
   } size_result_type;

   typedef struct packed {
      logic [63:0]     flen;
      logic [63:0]     base;
      logic            typed;
      size_result_type res;
      tensor_word_type w;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic  [3:0] req_dim_count = '0;
   logic [63:0] req_dim_zero = '0;
   logic [63:0] req_dim_one = '0;
   logic [63:0] req_dim_two = '0;
   logic [63:0] req_dim_three = '0;
   logic [31:0] req_storage_type = '0;
   logic [63:0] req_data_offset = '0;
   logic        rsp_valid;
   logic  [1:0] rsp_status;
   logic [63:0] rsp_byte_count;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [63:0] csr_wdata = '0;

   logic [63:0]     file_len_q = '0;
   logic [63:0]     data_base_q = '0;
   size_result_type sizes_due[$];
   int unsigned     mismatches = 0;
   int unsigned     idle_cycles = 0;

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{ZERO, ZERO, 1'b1, '{ST_RANGE, ZERO},
         '{4'd1, 64'd1, ZERO, ZERO, ZERO, KIND_W32, ZERO}},
      '{ZERO, ZERO, 1'b1, '{ST_RANGE, ZERO},
         '{4'd0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, KIND_W8, ZERO}},
      '{ZERO, ZERO, 1'b1, '{ST_FORMAT, ZERO},
         '{4'd5, 64'd1, 64'd1, 64'd1, 64'd1, KIND_W32, ZERO}},
      '{ZERO, ZERO, 1'b1, '{ST_FORMAT, ZERO},
         '{4'd15, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, KIND_TOP, ALL_ONES}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_OK, 64'd4},
         '{4'd0, ZERO, ZERO, ZERO, ZERO, KIND_W32, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_FORMAT, ZERO},
         '{4'd1, ZERO, 64'd5, 64'd5, 64'd5, KIND_W32, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_FORMAT, ZERO},
         '{4'd4, 64'd3, 64'd3, 64'd3, ZERO, KIND_W32, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_OK, 64'd16},
         '{4'd1, 64'd8, ZERO, ZERO, ZERO, KIND_W16, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_RANGE, ZERO},
         '{4'd3, 64'd1, BIT32, BIT32, ZERO, KIND_W32, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_OK, ALL_ONES},
         '{4'd2, 64'd1, ALL_ONES, ZERO, ZERO, KIND_W8, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_UNSUPPORTED, ZERO},
         '{4'd1, 64'd1, ZERO, ZERO, ZERO, KIND_GAP, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_UNSUPPORTED, ZERO},
         '{4'd1, 64'd1, ZERO, ZERO, ZERO, KIND_TOP, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_UNSUPPORTED, ZERO},
         '{4'd1, 64'd1, ZERO, ZERO, ZERO, KIND_HOLE, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_UNSUPPORTED, ZERO},
         '{4'd1, 64'd1, ZERO, ZERO, ZERO, KIND_PAST_END, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_UNSUPPORTED, ZERO},
         '{4'd1, 64'd33, ZERO, ZERO, ZERO, KIND_B32_18, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_UNSUPPORTED, ZERO},
         '{4'd1, BIT62, ZERO, ZERO, ZERO, KIND_W32, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_OK, 64'd8760},
         '{4'd4, 64'd256, 64'd2, 64'd3, 64'd5, KIND_B256_292, ZERO}},
      '{ALL_ONES, ZERO, 1'b1, '{ST_OK, 64'd168},
         '{4'd1, 64'd512, ZERO, ZERO, ZERO, KIND_B256_84, ZERO}},
      '{ALL_ONES, ZERO, 1'b0, '{ST_OK, ZERO},
         '{4'd2, 64'd96, 64'd7, ZERO, ZERO, KIND_B32_18, 64'd3}},
      '{ALL_ONES, ZERO, 1'b0, '{ST_OK, ZERO},
         '{4'd3, 64'd128, 64'd5, 64'd9, ZERO, KIND_B64_36, 64'd5}},
      '{64'd100, 64'd40, 1'b1, '{ST_OK, 64'd60},
         '{4'd1, 64'd15, ZERO, ZERO, ZERO, KIND_W32, ZERO}},
      '{64'd100, 64'd40, 1'b1, '{ST_RANGE, ZERO},
         '{4'd1, 64'd15, ZERO, ZERO, ZERO, KIND_W32, 64'd1}},
      '{64'd100, 64'd40, 1'b1, '{ST_RANGE, ZERO},
         '{4'd1, 64'd1, ZERO, ZERO, ZERO, KIND_W8, ALL_ONES}},
      '{64'd10, 64'd11, 1'b1, '{ST_RANGE, ZERO},
         '{4'd1, 64'd1, ZERO, ZERO, ZERO, KIND_W32, ZERO}},
      '{ALL_ONES, ALL_ONES, 1'b1, '{ST_RANGE, ZERO},
         '{4'd0, ZERO, ZERO, ZERO, ZERO, KIND_W8, ZERO}}
   };

   tensor_byte_size_check uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_dim_count    (req_dim_count),
      .req_dim_zero     (req_dim_zero),
      .req_dim_one      (req_dim_one),
      .req_dim_two      (req_dim_two),
      .req_dim_three    (req_dim_three),
      .req_storage_type (req_storage_type),
      .req_data_offset  (req_data_offset),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_byte_count   (rsp_byte_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic bit storage_layout(input logic [31:0] kind, output logic [63:0] blk,
                                         output logic [63:0] sz);
      blk = 64'd1;
      sz  = 64'd0;
      case (kind)
         32'd0: sz = 64'd4;
         32'd1: sz = 64'd2;
         32'd2: begin blk = 64'd32; sz = 64'd18; end
         32'd3: begin blk = 64'd32; sz = 64'd20; end
         32'd4: sz = 64'd8;
         32'd6: begin blk = 64'd32; sz = 64'd22; end
         32'd7: begin blk = 64'd32; sz = 64'd24; end
         32'd8: begin blk = 64'd32; sz = 64'd34; end
         32'd9: begin blk = 64'd32; sz = 64'd36; end
         32'd10: begin blk = 64'd256; sz = 64'd84; end
         32'd11: begin blk = 64'd256; sz = 64'd110; end
         32'd12: begin blk = 64'd256; sz = 64'd144; end
         32'd13: begin blk = 64'd256; sz = 64'd176; end
         32'd14: begin blk = 64'd256; sz = 64'd210; end
         32'd15: begin blk = 64'd256; sz = 64'd292; end
         32'd16: begin blk = 64'd256; sz = 64'd66; end
         32'd17: begin blk = 64'd256; sz = 64'd74; end
         32'd18: begin blk = 64'd256; sz = 64'd98; end
         32'd19: begin blk = 64'd256; sz = 64'd50; end
         32'd20: begin blk = 64'd32; sz = 64'd18; end
         32'd21: begin blk = 64'd256; sz = 64'd110; end
         32'd22: begin blk = 64'd256; sz = 64'd82; end
         32'd23: begin blk = 64'd256; sz = 64'd136; end
         32'd24: sz = 64'd1;
         32'd25: sz = 64'd2;
         32'd26: sz = 64'd4;
         32'd27: sz = 64'd8;
         32'd28: sz = 64'd8;
         32'd29: begin blk = 64'd256; sz = 64'd56; end
         32'd30: sz = 64'd2;
         32'd39: begin blk = 64'd32; sz = 64'd17; end
         32'd40: begin blk = 64'd64; sz = 64'd36; end
         32'd41: begin blk = 64'd32; sz = 64'd18; end
         32'd42: begin blk = 64'd64; sz = 64'd18; end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic size_result_type tensor_size(input tensor_word_type w);
      logic [63:0]     dims [4];
      logic [63:0]     rows;
      logic [63:0]     fast;
      logic [63:0]     blk;
      logic [63:0]     sz;
      logic [63:0]     room;
      logic [127:0]    wide;
      int unsigned     d;
      size_result_type r;
      r = '{ST_OK, ZERO};
      dims[0] = w.d0;
      dims[1] = w.d1;
      dims[2] = w.d2;
      dims[3] = w.d3;
      if (w.dims_n > MAX_DIMS) begin
         r.st = ST_FORMAT;
         return r;
      end
      for (d = 0; d < w.dims_n; d++) begin
         if (dims[d] == ZERO) begin
            r.st = ST_FORMAT;
            return r;
         end
      end
      rows = 64'd1;
      for (d = 1; d < w.dims_n; d++) begin
         wide = {64'd0, rows} * {64'd0, dims[d]};
         if (wide[127:64] != ZERO) begin
            r.st = ST_RANGE;
            return r;
         end
         rows = wide[63:0];
      end
      fast = (w.dims_n != 4'd0) ? w.d0 : 64'd1;
      if (!storage_layout(w.kind, blk, sz) || (fast % blk) != ZERO) begin
         r.st = ST_UNSUPPORTED;
         return r;
      end
      wide = {64'd0, rows} * {64'd0, fast / blk};
      if (wide[127:64] == ZERO)
         wide = {64'd0, wide[63:0]} * {64'd0, sz};
      if (wide[127:64] != ZERO) begin
         r.st = ST_UNSUPPORTED;
         return r;
      end
      if (data_base_q > file_len_q) begin
         r.st = ST_RANGE;
         return r;
      end
      room = file_len_q - data_base_q;
      if (w.off > room || wide[63:0] > room - w.off) begin
         r.st = ST_RANGE;
         return r;
      end
      r.nbytes = wide[63:0];
      return r;
   endfunction

   function automatic logic [63:0] rand_dim();
      case ($urandom_range(0, 19))
         0: return ZERO;
         1: return ALL_ONES;
         2: return {$urandom, $urandom};
         3: return 64'd1 << $urandom_range(0, 63);
         default: return 64'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic tensor_word_type random_word();
      tensor_word_type w;
      logic [63:0]     blk;
      logic [63:0]     sz;
      logic [63:0]     room;
      int unsigned     pick;
      pick = $urandom_range(0, 99);
      w.d0 = rand_dim();
      w.d1 = rand_dim();
      w.d2 = rand_dim();
      w.d3 = rand_dim();
      room = (data_base_q > file_len_q) ? ZERO : file_len_q - data_base_q;
      case ($urandom_range(0, 9))
         0: w.off = {$urandom, $urandom};
         1: w.off = room - 64'($urandom_range(0, 300));
         default: w.off = 64'($urandom_range(0, 4096));
      endcase
      if (pick < 15) begin
         w.dims_n = 4'($urandom);
         w.kind   = $urandom;
      end else begin
         w.dims_n = 4'($urandom_range(0, MAX_DIMS));
         do
            w.kind = $urandom_range(0, 43);
         while (!storage_layout(w.kind, blk, sz) && $urandom_range(0, 3) != 0);
         if (pick < 90 && storage_layout(w.kind, blk, sz))
            w.d0 = blk * (($urandom_range(0, 7) == 0) ? rand_dim()
                                                       : 64'($urandom_range(1, 24)));
      end
      return w;
   endfunction

   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input tensor_word_type w, input bit typed,
                            input size_result_type res);
      start            <= 1'b1;
      req_dim_count    <= w.dims_n;
      req_dim_zero     <= w.d0;
      req_dim_one      <= w.d1;
      req_dim_two      <= w.d2;
      req_dim_three    <= w.d3;
      req_storage_type <= w.kind;
      req_data_offset  <= w.off;
      do
         @(posedge clock);
      while (busy);
      sizes_due.push_back(typed ? res : tensor_size(w));
   endtask

   task automatic hold_off(input int unsigned n);
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sizes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_window(input logic [63:0] flen, input logic [63:0] base);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FILE_LENGTH;
      csr_wdata <= flen;
      @(posedge clock);
      csr_index <= CSR_DATA_START;
      csr_wdata <= base;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      file_len_q  = flen;
      data_base_q = base;
   endtask

   always @(posedge clock) begin : check_rsp
      size_result_type want;
      if (!reset && rsp_valid) begin
         if (sizes_due.size() == 0) begin
            $error("unexpected word: status %0d byte_count %0h", rsp_status, rsp_byte_count);
            mismatches++;
         end else begin
            want = sizes_due.pop_front();
            if (rsp_status !== want.st) begin
               $error("status: expected %0d, got %0d", want.st, rsp_status);
               mismatches++;
            end
            if (rsp_byte_count !== want.nbytes) begin
               $error("byte_count: expected %0h, got %0h", want.nbytes, rsp_byte_count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tensor_byte_size_check regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : drive
      logic [63:0] flen;
      logic [63:0] base;
      int unsigned i;
      int unsigned p;
      int unsigned k;
      bit          steady;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].flen != file_len_q || directed_rows[i].base != data_base_q) begin
            drain();
            set_window(directed_rows[i].flen, directed_rows[i].base);
         end
         send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].res);
         hold_off(pause_len());
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p)
            0: begin flen = ALL_ONES; base = ZERO; end
            1: begin flen = ZERO; base = ZERO; end
            2: begin flen = ALL_ONES; base = ALL_ONES; end
            3: begin
               flen = 64'($urandom_range(0, 4096));
               base = flen + 64'($urandom_range(1, 100));
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: flen = {$urandom, $urandom};
                  1: flen = 64'($urandom_range(0, 1 << 20));
                  default: flen = ALL_ONES;
               endcase
               base = {$urandom, $urandom};
               if (flen != ALL_ONES) base = base % (flen + 64'd1);
            end
         endcase
         set_window(flen, base);
         steady = ($urandom_range(0, 3) == 0);
         for (k = 0; k < WORDS_PER_PHASE; k++) begin
            send_word(random_word(), 1'b0, '0);
            if (!steady) hold_off(pause_len());
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("tensor_byte_size_check regression: pass");
      else
         $display("tensor_byte_size_check regression: fail");
      $finish;
   end

endmodule

### filelist.f
sv/tbsc_pkg.sv
sv/tbsc_mul64.sv
sv/tbsc_front.sv
sv/tbsc_queue.sv
sv/tbsc_back.sv
sv/tensor_byte_size_check.sv
dv/tensor_byte_size_check_tb.sv
